// File: hdl/hwse_pkg.sv
// shared types, constants and slot map for the hit word map and strip extract block
package hwse_pkg;

  localparam int WORD_W      = 32;
  localparam int IDX_W       = 6;
  localparam int SENSOR_W    = 2;
  localparam int CHIP_W      = 4;
  localparam int SLOT_W      = SENSOR_W + CHIP_W;
  localparam int STORE_DEPTH = 64;
  localparam int STRIP_W     = 11;
  localparam int SID_W       = 8;
  localparam int MAP_N       = 32;
  localparam int MAP_IDX_W   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] MAP_FIRST = 6'd2;
  localparam logic [IDX_W-1:0] MAP_LAST  = 6'd33;

  // chips whose strips run in the opposite direction
  localparam logic [15:0] MIRROR_CHIPS = 16'hE8E8;

  localparam logic [SID_W-1:0] SENSOR_ID_BASE = 8'd128;

  localparam int DEF_BITS_PER_WORD = 32;
  localparam int STRIPS_PER_BIT    = 4;
  localparam int STRIPS_PER_CHIP   = 128;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SCAN = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  // store slot of the first-section word, per mapped word index
  localparam slot_t SLOT_MAP_A [MAP_N] = '{
    6'd2,  6'd0,  6'd29, 6'd31, 6'd45, 6'd47, 6'd50, 6'd48,
    6'd5,  6'd7,  6'd26, 6'd24, 6'd42, 6'd40, 6'd53, 6'd55,
    6'd10, 6'd8,  6'd21, 6'd23, 6'd37, 6'd39, 6'd58, 6'd56,
    6'd13, 6'd15, 6'd18, 6'd16, 6'd34, 6'd32, 6'd61, 6'd63
  };

  // store slot of the second-section word
  localparam slot_t SLOT_MAP_B [MAP_N] = '{
    6'd1,  6'd3,  6'd30, 6'd28, 6'd46, 6'd44, 6'd49, 6'd51,
    6'd6,  6'd4,  6'd25, 6'd27, 6'd41, 6'd43, 6'd54, 6'd52,
    6'd9,  6'd11, 6'd22, 6'd20, 6'd38, 6'd36, 6'd57, 6'd59,
    6'd14, 6'd12, 6'd17, 6'd19, 6'd33, 6'd35, 6'd62, 6'd60
  };

  typedef struct packed {
    logic                is_scan;
    slot_t               slot_a;
    slot_t               slot_b;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
    logic [SENSOR_W-1:0] sensor;
    logic [CHIP_W-1:0]   chip;
  } cmd_t;

endpackage

// File: hdl/hwse_if.sv
// request channels of the hit word map and strip extract block
interface hwse_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [hwse_pkg::IDX_W-1:0]    word_index;
  logic [hwse_pkg::WORD_W-1:0]   first_word;
  logic [hwse_pkg::WORD_W-1:0]   second_word;
  logic [hwse_pkg::SENSOR_W-1:0] sensor_sel;
  logic [hwse_pkg::CHIP_W-1:0]   chip_sel;

  modport source (output valid, mode, word_index, first_word, second_word, sensor_sel,
                  chip_sel, input ready);
  modport sink (input valid, mode, word_index, first_word, second_word, sensor_sel,
                chip_sel, output ready);
endinterface

interface hwse_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit_valid;
  logic [hwse_pkg::SID_W-1:0]   sensor_id;
  logic [hwse_pkg::STRIP_W-1:0] strip;
  logic                         last;

  modport source (output valid, hit_valid, sensor_id, strip, last, input ready);
  modport sink (input valid, hit_valid, sensor_id, strip, last, output ready);
endinterface

// File: hdl/hit_word_map_and_strip_extract_top.sv
// top level of the hit word map and strip extract block
// Keeps 64 hit words of 32 bits, one per sensor/chip slot (sensor*16+chip), all zero
// after reset and never cleared between events. A load request (mode 0) with
// word_index 2..33 writes its two words into the two slots of the fixed map; other
// indices are accepted and dropped. A scan request (mode 1) reads one slot and sends
// one result per set bit, low bit first, with sensor id 128+sensor and the strip
// number (mirrored on chips 3,5,6,7,11,13,14,15); an empty word gives a single
// result with hit_valid low and last high. Requests enter a two-entry queue and are
// accepted one per cycle while it has room. The back end holds a single-write-port
// store, so a load writes its first word on the pop and its second in B_WR2; a scan
// reads the store, then gives one result per cycle (at least one) while the output register is free.
module hit_word_map_and_strip_extract_top #(
  parameter int BITS_PER_WORD = hwse_pkg::DEF_BITS_PER_WORD
) (
  input  logic        clk,
  input  logic        rst_n,
  hwse_in_if.sink     in_ch,
  hwse_out_if.source  out_ch
);

  // queue handshake between front end and back end
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  hwse_pkg::cmd_t  q_wdata;
  hwse_pkg::cmd_t  q_rdata;

  // classify requests and resolve store slots
  hwse_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // decouples request intake from store access and scanning
  hwse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // store writes, store reads and per-hit result generation
  hwse_back #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/hwse_front.sv
// front end: takes requests, drops unmapped loads, resolves store slots
module hwse_front (
  hwse_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output hwse_pkg::cmd_t  q_data
);

  logic                              mapped;
  logic [hwse_pkg::IDX_W-1:0]        ofs;
  logic [hwse_pkg::MAP_IDX_W-1:0]    map_idx;

  assign in_ch.ready = !q_full;

  assign mapped  = (in_ch.word_index >= hwse_pkg::MAP_FIRST) &&
                   (in_ch.word_index <= hwse_pkg::MAP_LAST);
  assign ofs     = in_ch.word_index - hwse_pkg::MAP_FIRST;
  assign map_idx = ofs[hwse_pkg::MAP_IDX_W-1:0];

  assign q_push = in_ch.valid && !q_full &&
                  ((in_ch.mode == hwse_pkg::MODE_SCAN) || mapped);

  always_comb begin
    q_data.is_scan = (in_ch.mode == hwse_pkg::MODE_SCAN);
    q_data.slot_a  = hwse_pkg::SLOT_MAP_A[map_idx];
    q_data.slot_b  = hwse_pkg::SLOT_MAP_B[map_idx];
    q_data.word_a  = in_ch.first_word;
    q_data.word_b  = in_ch.second_word;
    q_data.sensor  = in_ch.sensor_sel;
    q_data.chip    = in_ch.chip_sel;
  end

endmodule

// File: hdl/hwse_queue.sv
// short command queue between front end and back end
module hwse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hwse_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output hwse_pkg::cmd_t  pop_data,
  output logic            empty
);

  localparam int DEPTH = hwse_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hwse_pkg::cmd_t   ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/hwse_back.sv
// back end: hit word store, load writes and bit-by-bit strip scan
module hwse_back #(
  parameter int BITS_PER_WORD = hwse_pkg::DEF_BITS_PER_WORD
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  hwse_pkg::cmd_t  q_data,
  output logic            q_pop,
  hwse_out_if.source      out_ch
);

  localparam int POS_W = $clog2(BITS_PER_WORD);

  typedef enum logic [1:0] {B_IDLE, B_WR2, B_RD, B_SCAN} st_t;

  st_t st_r;

  // hit word store, with one valid bit per entry standing in for the reset clear
  logic [hwse_pkg::WORD_W-1:0]      mem_r [hwse_pkg::STORE_DEPTH];
  logic [hwse_pkg::STORE_DEPTH-1:0] vld_r;
  logic [hwse_pkg::WORD_W-1:0]      rd_data_r;
  logic                             rd_vld_r;

  logic                             wr_en;
  hwse_pkg::slot_t                  wr_addr;
  logic [hwse_pkg::WORD_W-1:0]      wr_data;
  logic                             rd_en;
  hwse_pkg::slot_t                  rd_addr;

  hwse_pkg::slot_t                  slot_b_r;
  logic [hwse_pkg::WORD_W-1:0]      word_b_r;
  logic [hwse_pkg::SENSOR_W-1:0]    sensor_r;
  logic [hwse_pkg::CHIP_W-1:0]      chip_r;
  logic [BITS_PER_WORD-1:0]         word_r;
  logic                             empty_r;

  logic                             out_vld_r;
  logic                             out_hit_r;
  logic [hwse_pkg::SID_W-1:0]       out_sid_r;
  logic [hwse_pkg::STRIP_W-1:0]     out_strip_r;
  logic                             out_last_r;

  logic [BITS_PER_WORD-1:0]         rd_word;
  logic [BITS_PER_WORD-1:0]         iso;
  logic [BITS_PER_WORD-1:0]         rest;
  logic [POS_W-1:0]                 bit_pos;
  logic [POS_W-1:0]                 pos_m;
  logic                             mirrored;
  logic [31:0]                      strip_full;
  logic                             out_free;
  logic                             scan_done;

  assign q_pop   = (st_r == B_IDLE) && !q_empty;
  assign wr_en   = (q_pop && !q_data.is_scan) || (st_r == B_WR2);
  assign wr_addr = (st_r == B_WR2) ? slot_b_r : q_data.slot_a;
  assign wr_data = (st_r == B_WR2) ? word_b_r : q_data.word_a;
  assign rd_en   = q_pop && q_data.is_scan;
  assign rd_addr = {q_data.sensor, q_data.chip};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r[BITS_PER_WORD-1:0] : '0;

  // lowest set bit and the word with it removed
  assign iso  = word_r & (~word_r + 1'b1);
  assign rest = word_r & (word_r - 1'b1);

  always_comb begin
    bit_pos = '0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      if (iso[i]) begin
        bit_pos = bit_pos | POS_W'(i);
      end
    end
  end

  assign mirrored   = hwse_pkg::MIRROR_CHIPS[chip_r];
  assign pos_m      = mirrored ? (POS_W'(BITS_PER_WORD - 1) - bit_pos) : bit_pos;
  assign strip_full = 32'(hwse_pkg::STRIPS_PER_BIT) * 32'(pos_m) +
                      32'(chip_r) * 32'(hwse_pkg::STRIPS_PER_CHIP);

  assign out_free  = !out_vld_r || out_ch.ready;
  assign scan_done = empty_r || (rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if ((st_r == B_SCAN) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            sensor_r <= q_data.sensor;
            chip_r   <= q_data.chip;
            slot_b_r <= q_data.slot_b;
            word_b_r <= q_data.word_b;
            st_r     <= q_data.is_scan ? B_RD : B_WR2;
          end
        end
        B_WR2: begin
          st_r <= B_IDLE;
        end
        B_RD: begin
          word_r  <= rd_word;
          empty_r <= (rd_word == '0);
          st_r    <= B_SCAN;
        end
        B_SCAN: begin
          if (out_free) begin
            out_hit_r   <= !empty_r;
            out_sid_r   <= hwse_pkg::SENSOR_ID_BASE + hwse_pkg::SID_W'(sensor_r);
            out_strip_r <= empty_r ? '0 : strip_full[hwse_pkg::STRIP_W-1:0];
            out_last_r  <= scan_done;
            word_r      <= rest;
            if (scan_done) begin
              st_r <= B_IDLE;
            end
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.hit_valid = out_hit_r;
  assign out_ch.sensor_id = out_sid_r;
  assign out_ch.strip     = out_strip_r;
  assign out_ch.last      = out_last_r;

  a_wr2_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_WR2) |-> ($past(st_r) == B_IDLE))
    else $error("second store write not preceded by a load pop");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_hit_r) |-> out_last_r)
    else $error("empty scan result without last");

  a_hit_continues: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == B_SCAN) && out_free && !scan_done) |=> (st_r == B_SCAN))
    else $error("scan left before all hits sent");

  a_rd_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RD) |=> (st_r == B_SCAN))
    else $error("store read not followed by scan");

endmodule

// File: verif/tb_hit_word_map_and_strip_extract_top.sv
// testbench for the hit word map and strip extract block: stored word pairs, scans, strip checks
module tb_hit_word_map_and_strip_extract_top;

  localparam int HIT_BITS      = 32;
  localparam int STRIP_STEP    = 4;
  localparam int CHIP_STRIPS   = 128;
  localparam int SENSOR_ID_LOW = 128;
  localparam int MAPPED_LOW    = 2;
  localparam int MAPPED_HIGH   = 33;
  localparam int RANDOM_COUNT  = 156;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int MAX_REPORTS   = 20;

  // chips whose strips count down within the chip
  localparam logic [15:0] MIRRORED_CHIPS = 16'hE8E8;

  // store slots (sensor*16+chip) fed by each mapped word index, first and second section
  localparam int FIRST_SLOT [32] = '{
     2,  0, 29, 31, 45, 47, 50, 48,  5,  7, 26, 24, 42, 40, 53, 55,
    10,  8, 21, 23, 37, 39, 58, 56, 13, 15, 18, 16, 34, 32, 61, 63
  };
  localparam int SECOND_SLOT [32] = '{
     1,  3, 30, 28, 46, 44, 49, 51,  6,  4, 25, 27, 41, 43, 54, 52,
     9, 11, 22, 20, 38, 36, 57, 59, 14, 12, 17, 19, 33, 35, 62, 60
  };

  typedef struct {
    logic                          mode;
    logic [hwse_pkg::IDX_W-1:0]    word_index;
    logic [hwse_pkg::WORD_W-1:0]   first_word;
    logic [hwse_pkg::WORD_W-1:0]   second_word;
    logic [hwse_pkg::SENSOR_W-1:0] sensor_sel;
    logic [hwse_pkg::CHIP_W-1:0]   chip_sel;
  } request_t;

  typedef struct {
    logic                         hit_valid;
    logic [hwse_pkg::SID_W-1:0]   sensor_id;
    logic [hwse_pkg::STRIP_W-1:0] strip;
    logic                         last;
  } hit_t;

  logic clk;
  logic rst_n;

  hwse_in_if  in_ch ();
  hwse_out_if out_ch ();

  hit_word_map_and_strip_extract_top #(
    .BITS_PER_WORD(HIT_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  request_t    req_queue[$];
  hit_t        expected_hits[$];
  logic [31:0] hit_store[64];
  int          loaded_slots[$];

  int total_requests;
  int requests_taken;
  int fail_count;
  int load_count;
  int unmapped_count;
  int scan_count;
  int empty_scan_count;
  int hits_checked;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // length of an idle stretch: mostly none or short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // word patterns: empty, full, single bit, sparse, dense random
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3, 4, 5: return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(input int idx, input logic [31:0] w1, input logic [31:0] w2);
    request_t rq;
    rq.mode        = hwse_pkg::MODE_LOAD;
    rq.word_index  = idx[hwse_pkg::IDX_W-1:0];
    rq.first_word  = w1;
    rq.second_word = w2;
    rq.sensor_sel  = hwse_pkg::SENSOR_W'($urandom_range(0, 3));
    rq.chip_sel    = hwse_pkg::CHIP_W'($urandom_range(0, 15));
    req_queue.insert(req_queue.size(), rq);
    if (idx >= MAPPED_LOW && idx <= MAPPED_HIGH) begin
      loaded_slots.insert(loaded_slots.size(), FIRST_SLOT[idx - MAPPED_LOW]);
      loaded_slots.insert(loaded_slots.size(), SECOND_SLOT[idx - MAPPED_LOW]);
    end
  endtask

  task automatic push_scan(input int sensor, input int chip);
    request_t rq;
    rq.mode        = hwse_pkg::MODE_SCAN;
    rq.word_index  = hwse_pkg::IDX_W'($urandom_range(0, 63));
    rq.first_word  = $urandom;
    rq.second_word = $urandom;
    rq.sensor_sel  = sensor[hwse_pkg::SENSOR_W-1:0];
    rq.chip_sel    = chip[hwse_pkg::CHIP_W-1:0];
    req_queue.insert(req_queue.size(), rq);
  endtask

  // store update for loads, hit list for scans
  task automatic predict_request(input request_t rq);
    logic [31:0] word;
    int          total;
    int          n;
    int          pos;
    hit_t        h;
    if (rq.mode == hwse_pkg::MODE_LOAD) begin
      load_count++;
      if (rq.word_index >= MAPPED_LOW && rq.word_index <= MAPPED_HIGH) begin
        hit_store[FIRST_SLOT[rq.word_index - MAPPED_LOW]]  = rq.first_word;
        hit_store[SECOND_SLOT[rq.word_index - MAPPED_LOW]] = rq.second_word;
      end else begin
        unmapped_count++;
      end
    end else begin
      scan_count++;
      word        = hit_store[{rq.sensor_sel, rq.chip_sel}];
      total       = $countones(word);
      h.sensor_id = hwse_pkg::SID_W'(SENSOR_ID_LOW + rq.sensor_sel);
      if (total == 0) begin
        empty_scan_count++;
        h.hit_valid = 1'b0;
        h.strip     = '0;
        h.last      = 1'b1;
        expected_hits.insert(expected_hits.size(), h);
      end else begin
        n = 0;
        for (int i = 0; i < HIT_BITS; i++) begin
          if (word[i]) begin
            pos         = MIRRORED_CHIPS[rq.chip_sel] ? HIT_BITS - 1 - i : i;
            h.hit_valid = 1'b1;
            h.strip     = hwse_pkg::STRIP_W'(STRIP_STEP * pos + rq.chip_sel * CHIP_STRIPS);
            h.last      = (n == total - 1);
            expected_hits.insert(expected_hits.size(), h);
            n++;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // request driver
  int       gap_left;
  int       calm_left;
  request_t taken;
  request_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= hwse_pkg::MODE_LOAD;
      in_ch.word_index  <= '0;
      in_ch.first_word  <= '0;
      in_ch.second_word <= '0;
      in_ch.sensor_sel  <= '0;
      in_ch.chip_sel    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.mode        = in_ch.mode;
        taken.word_index  = in_ch.word_index;
        taken.first_word  = in_ch.first_word;
        taken.second_word = in_ch.second_word;
        taken.sensor_sel  = in_ch.sensor_sel;
        taken.chip_sel    = in_ch.chip_sel;
        predict_request(taken);
        requests_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          next_req          = req_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= next_req.mode;
          in_ch.word_index  <= next_req.word_index;
          in_ch.first_word  <= next_req.first_word;
          in_ch.second_word <= next_req.second_word;
          in_ch.sensor_sel  <= next_req.sensor_sel;
          in_ch.chip_sel    <= next_req.chip_sel;
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_pause();
            if ($urandom_range(0, 99) < 8) calm_left = $urandom_range(8, 30);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and backpressure
  int   stall_left;
  int   steady_left;
  hit_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: unexpected result, expected none actual hit_valid %0b",
                      " sensor_id %0d strip %0d last %0b"},
                     $time, out_ch.hit_valid, out_ch.sensor_id, out_ch.strip, out_ch.last);
        end else begin
          want = expected_hits.pop_front();
          check_field("hit_valid", 16'(want.hit_valid), 16'(out_ch.hit_valid));
          check_field("sensor_id", 16'(want.sensor_id), 16'(out_ch.sensor_id));
          check_field("strip", 16'(want.strip), 16'(out_ch.strip));
          check_field("last", 16'(want.last), 16'(out_ch.last));
          hits_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (steady_left > 0) steady_left--;
        else if ($urandom_range(0, 99) < 25) stall_left = pick_pause();
        else if ($urandom_range(0, 99) < 5) steady_left = $urandom_range(10, 40);
      end
    end
  end

  // watchdog on cycles with no request taken and no expected result taken
  int idle_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready && expected_hits.size() != 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
          $display("tb_hit_word_map_and_strip_extract_top failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int r;
    int idx;
    int slot;
    rst_n = 1'b0;
    for (int i = 0; i < 64; i++) hit_store[i] = '0;

    // store is empty after reset
    push_scan(0, 0);
    push_scan(3, 15);
    // unmapped indices leave the store alone
    push_load(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_load(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_load(34, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_load(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_scan(0, 2);
    push_scan(3, 15);
    // lowest mapped index, plain chips, end bits
    push_load(2, 32'h8000_0001, 32'h0000_0001);
    push_scan(0, 2);
    push_scan(0, 1);
    // highest mapped index: full mirrored word and top bit on a plain chip
    push_load(33, 32'hFFFF_FFFF, 32'h8000_0000);
    push_scan(3, 15);
    push_scan(3, 12);
    // mirrored chip, bit 0 lands on the top strip
    push_load(5, 32'h0000_0001, 32'h0000_0000);
    push_scan(1, 15);
    push_scan(1, 12);
    push_load(3, 32'h0000_0003, 32'h0000_0001);
    push_scan(0, 3);
    push_scan(0, 0);
    // overwrite with zero
    push_load(2, 32'h0, 32'h0);
    push_scan(0, 2);
    // scan straight after the load that feeds it
    push_load(4, 32'h5555_AAAA, 32'hA5A5_5A5A);
    push_scan(1, 13);
    push_scan(1, 14);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if (r < 5) begin
          idx = $urandom_range(0, 31);
          if (idx >= 2) idx = idx + 32;
        end else begin
          idx = $urandom_range(MAPPED_LOW, MAPPED_HIGH);
        end
        push_load(idx, random_word(), random_word());
      end else begin
        if (loaded_slots.size() != 0 && $urandom_range(0, 99) < 75)
          slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        else
          slot = $urandom_range(0, 63);
        push_scan(slot / 16, slot % 16);
      end
    end
    total_requests = req_queue.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < total_requests || expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_hits.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_hits.size());
    end
    $display("sent %0d loads (%0d to unmapped indices) and %0d scans (%0d of empty words)",
             load_count, unmapped_count, scan_count, empty_scan_count);
    $display("checked %0d results with random gaps on requests and random backpressure",
             hits_checked);
    if (fail_count == 0) begin
      $display("tb_hit_word_map_and_strip_extract_top passed");
    end else begin
      $display("tb_hit_word_map_and_strip_extract_top failed");
    end
    $finish;
  end

endmodule
